// File: rtl/core/b64d_pkg.sv
`timescale 1ns / 1ps
// b64d_pkg: shared types, codes and the character classifier of the base64 stream decoder
// no dependencies; imported by the front, back and top-level modules of the decoder

package b64d_pkg;

  // character classes as reported on char_class
  localparam logic [1:0] CLS_ALPHA   = 2'd0;
  localparam logic [1:0] CLS_SPACE   = 2'd1;
  localparam logic [1:0] CLS_INVALID = 2'd2;

  // alphabet_mode codes
  localparam logic [1:0] MODE_STD  = 2'd0;
  localparam logic [1:0] MODE_URL  = 2'd1;

  // configuration register indexes
  localparam logic REG_ALPHABET_MODE = 1'b0;
  localparam logic REG_SKIP_INVALID  = 1'b1;

  // whitespace characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // queue depths
  localparam int MID_DEPTH_DEFAULT = 2;
  localparam int OUT_DEPTH_DEFAULT = 2;

  // classified character handed from front to back
  typedef struct packed {
    logic       last;
    logic       bad;
    logic [1:0] cls;
    logic [5:0] sextet;
  } front_item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] char_class;
    logic       bad_char;
    logic [1:0] leftover_sextets;
    logic       last_out;
  } result_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [5:0] sextet;
  } class_t;

  function automatic class_t classify(input logic [7:0] c, input logic [1:0] mode);
    class_t r;
    logic   std_ok;
    logic   url_ok;
    logic [7:0] t;
    std_ok   = (mode != MODE_URL);
    url_ok   = (mode != MODE_STD);
    r.cls    = CLS_INVALID;
    r.sextet = 6'd0;
    t        = 8'd0;
    if (c inside {[8'h41:8'h5a]}) begin
      t        = c - 8'h41;
      r.cls    = CLS_ALPHA;
      r.sextet = t[5:0];
    end else if (c inside {[8'h61:8'h7a]}) begin
      t        = c - 8'h47;
      r.cls    = CLS_ALPHA;
      r.sextet = t[5:0];
    end else if (c inside {[8'h30:8'h39]}) begin
      t        = c + 8'h04;
      r.cls    = CLS_ALPHA;
      r.sextet = t[5:0];
    end else if ((std_ok && c == 8'h2b) || (url_ok && c == 8'h2d)) begin
      r.cls    = CLS_ALPHA;
      r.sextet = 6'd62;
    end else if ((std_ok && c == 8'h2f) || (url_ok && c == 8'h5f)) begin
      r.cls    = CLS_ALPHA;
      r.sextet = 6'd63;
    end else if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_FF, CH_CR}) begin
      r.cls    = CLS_SPACE;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/b64d_fifo.sv
`timescale 1ns / 1ps
// b64d_fifo: small register-based queue with fall-through read
// no package dependency; used between front and back and at the result side

module b64d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/b64d_front.sv
`timescale 1ns / 1ps
// b64d_front: accepts characters and classifies them into a registered stage
// depends on b64d_pkg (classify, front_item_t)

module b64d_front
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  alphabet_mode,
  input  logic        skip_invalid,
  input  logic        push,
  input  logic [7:0]  in_char,
  input  logic        end_of_input,
  output logic        full,
  output logic        item_valid,
  output front_item_t item,
  input  logic        item_full
);

  class_t c;
  logic   accept;
  logic   drain;

  assign c          = classify(in_char, alphabet_mode);
  assign drain      = item_valid && !item_full;
  assign full       = item_valid && item_full;
  assign accept     = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (drain) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.last   <= end_of_input;
      item.bad    <= (c.cls == CLS_INVALID) && !skip_invalid;
      item.cls    <= c.cls;
      item.sextet <= c.sextet;
    end
  end

endmodule

// File: rtl/core/b64d_back.sv
`timescale 1ns / 1ps
// b64d_back: group state (sextet count, bit accumulator) and byte assembly
// depends on b64d_pkg (front_item_t, result_t)

module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  front_item_t item,
  output result_t     result
);

  logic [1:0] sextet_count;
  logic [5:0] bit_accumulator;
  logic [1:0] sextet_count_next;
  logic [5:0] bit_accumulator_next;
  logic [1:0] count_step;
  logic [5:0] acc_step;
  logic [7:0] byte_val;
  logic       byte_ok;

  always_comb begin
    count_step = sextet_count;
    acc_step   = bit_accumulator;
    byte_val   = 8'd0;
    byte_ok    = 1'b0;
    if (item.cls == CLS_ALPHA) begin
      count_step = sextet_count + 2'd1;
      case (sextet_count)
        2'd0: begin
          acc_step = item.sextet;
        end
        2'd1: begin
          byte_val = {bit_accumulator, item.sextet[5:4]};
          byte_ok  = 1'b1;
          acc_step = {2'b00, item.sextet[3:0]};
        end
        2'd2: begin
          byte_val = {bit_accumulator[3:0], item.sextet[5:2]};
          byte_ok  = 1'b1;
          acc_step = {4'b0000, item.sextet[1:0]};
        end
        default: begin
          byte_val = {bit_accumulator[1:0], item.sextet};
          byte_ok  = 1'b1;
          acc_step = 6'd0;
        end
      endcase
    end
    sextet_count_next    = item.last ? 2'd0 : count_step;
    bit_accumulator_next = item.last ? 6'd0 : acc_step;

    result.data_byte        = byte_val;
    result.byte_valid       = byte_ok;
    result.char_class       = item.cls;
    result.bad_char         = item.bad;
    result.leftover_sextets = item.last ? count_step : 2'd0;
    result.last_out         = item.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_count    <= 2'd0;
      bit_accumulator <= 6'd0;
    end else if (take) begin
      sextet_count    <= sextet_count_next;
      bit_accumulator <= bit_accumulator_next;
    end
  end

endmodule

// File: rtl/core/base64_stream_decoder.sv
`timescale 1ns / 1ps
// base64_stream_decoder: top level of the streaming base64 character decoder
// depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back
//
// usage:
//   input side is a queue write port: one character per transaction, taken at
//   a rising edge with push high and full low; end_of_input marks the final
//   character of a stream and resets the group state after it
//   result side is a queue read port: while empty is low the oldest result is
//   on the result ports, taken at a rising edge with pop high
//   every input transaction yields exactly one result transaction
//   configuration (alphabet_mode at index 0, skip_invalid at index 1) is written
//   through cfg_we / cfg_index / cfg_data while the decoder holds no work
// timing:
//   an input transaction passes the classify register, then the front-to-back
//   queue, then the fall-through result queue, whose head drives the result ports
//   throughput is one character per cycle while no queue is full, as the back
//   end updates the group state for every character that it takes
// reset (synchronous, rst high) clears all queues, group state and registers
// when the receiver stalls, the result queue fills, then the middle queue,
// then the classify stage, and only then does full rise

module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEFAULT,
  parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  // input queue port
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       end_of_input,
  // result queue port
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic [1:0] char_class,
  output logic       bad_char,
  output logic [1:0] leftover_sextets,
  output logic       last_out
);

  // configuration registers
  logic [1:0] alphabet_mode;
  logic       skip_invalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_mode <= MODE_STD;
      skip_invalid  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHABET_MODE: alphabet_mode <= cfg_data;
        REG_SKIP_INVALID:  skip_invalid  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: classify stage
  logic        front_valid;
  front_item_t front_item;
  logic        mid_full;

  b64d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .alphabet_mode(alphabet_mode),
    .skip_invalid (skip_invalid),
    .push         (push),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .full         (full),
    .item_valid   (front_valid),
    .item         (front_item),
    .item_full    (mid_full)
  );

  // queue between classify and group logic
  logic [$bits(front_item_t)-1:0] mid_rdata;
  front_item_t                    mid_item;
  logic                           mid_empty;
  logic                           back_take;
  logic                           out_full;

  assign back_take = !mid_empty && !out_full;
  assign mid_item  = front_item_t'(mid_rdata);

  b64d_fifo #(
    .WIDTH($bits(front_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (front_valid),
    .wdata(front_item),
    .full (mid_full),
    .pop  (back_take),
    .rdata(mid_rdata),
    .empty(mid_empty)
  );

  // back: group state and byte assembly
  result_t back_result;

  b64d_back u_back (
    .clk   (clk),
    .rst   (rst),
    .take  (back_take),
    .item  (mid_item),
    .result(back_result)
  );

  // result queue, parts the receiver from the decoder
  logic [$bits(result_t)-1:0] out_rdata;
  result_t                    out_item;

  b64d_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (back_take),
    .wdata(back_result),
    .full (out_full),
    .pop  (pop),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign out_item         = result_t'(out_rdata);
  assign data_byte        = out_item.data_byte;
  assign byte_valid       = out_item.byte_valid;
  assign char_class       = out_item.char_class;
  assign bad_char         = out_item.bad_char;
  assign leftover_sextets = out_item.leftover_sextets;
  assign last_out         = out_item.last_out;

  // leftover count only appears on the last transaction of a stream
  a_leftover_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && leftover_sextets != 2'd0) |-> last_out)
    else $error("leftover sextets reported on a non-final result");

  // a byte is only completed by an alphabet character
  a_byte_alpha: assert property (@(posedge clk) disable iff (rst)
    (!empty && byte_valid) |-> (char_class == CLS_ALPHA))
    else $error("byte emitted for a non-alphabet character");

  // flagged characters are invalid ones
  a_bad_invalid: assert property (@(posedge clk) disable iff (rst)
    (!empty && bad_char) |-> (char_class == CLS_INVALID))
    else $error("bad_char set on a valid character");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for base64_stream_decoder, a clocked driver and monitor
// around a scoreboard fed by a built-in decode predictor
// depends on b64d_pkg (class, mode and register codes, result_t) and the decoder rtl

module tb;
  import b64d_pkg::*;

  // alphabet modes with no name in the package
  localparam logic [1:0] MODE_BOTH  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int MAX_PRINTED = 30;

  // one input transaction: character plus end-of-stream mark
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_char = 8'd0;
  logic       end_of_input = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [1:0] char_class;
  logic       bad_char;
  logic [1:0] leftover_sextets;
  logic       last_out;

  // characters waiting to be offered, and decoded results waiting to come out
  char_item_t char_q[$];
  result_t    pending_results[$];

  // predictor copy of the decoder registers and group state
  logic [1:0] cfg_mode = MODE_STD;
  logic       cfg_skip = 1'b0;
  logic [1:0] grp_count = 2'd0;
  logic [5:0] grp_bits = 6'd0;

  // idling controls, set per phase by the stimulus process
  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;

  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold_left = 0;
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int bytes_seen = 0;
  int bad_seen = 0;
  int streams_seen = 0;
  int full_stalls = 0;

  base64_stream_decoder dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .in_char          (in_char),
    .end_of_input     (end_of_input),
    .empty            (empty),
    .pop              (pop),
    .data_byte        (data_byte),
    .byte_valid       (byte_valid),
    .char_class       (char_class),
    .bad_char         (bad_char),
    .leftover_sextets (leftover_sextets),
    .last_out         (last_out)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // decode predictor
  // ---------------------------------------------------------------------------

  // character to class and sextet value under the given alphabet mode
  function automatic void map_char(input logic [7:0] ch, input logic [1:0] mode,
                                   output logic [1:0] cls, output logic [5:0] val);
    logic std_on;
    logic url_on;
    // modes 2 and the spare code 3 both take either alphabet
    std_on = (mode != MODE_URL);
    url_on = (mode != MODE_STD);
    cls = CLS_ALPHA;
    val = 6'd0;
    if (ch >= "A" && ch <= "Z") begin
      val = 6'(ch - "A");
    end else if (ch >= "a" && ch <= "z") begin
      val = 6'(ch - "a" + 8'd26);
    end else if (ch >= "0" && ch <= "9") begin
      val = 6'(ch - "0" + 8'd52);
    end else if ((std_on && ch == "+") || (url_on && ch == "-")) begin
      val = 6'd62;
    end else if ((std_on && ch == "/") || (url_on && ch == "_")) begin
      val = 6'd63;
    end else if (ch inside {CH_SPACE, CH_TAB, CH_LF, CH_FF, CH_CR}) begin
      cls = CLS_SPACE;
    end else begin
      // anything else, including every byte with the top bit set
      cls = CLS_INVALID;
    end
  endfunction

  // advance the group state by one character and return the expected result
  function automatic result_t decode_step(input char_item_t it);
    result_t    r;
    logic [1:0] cls;
    logic [5:0] val;
    map_char(it.ch, cfg_mode, cls, val);
    r = '0;
    r.char_class = cls;
    r.last_out = it.eoi;
    if (cls == CLS_ALPHA) begin
      // second, third and fourth sextet of a group each finish one byte
      case (grp_count)
        2'd0: begin
          grp_bits = val;
        end
        2'd1: begin
          r.data_byte  = {grp_bits, val[5:4]};
          r.byte_valid = 1'b1;
          grp_bits     = {2'b00, val[3:0]};
        end
        2'd2: begin
          r.data_byte  = {grp_bits[3:0], val[5:2]};
          r.byte_valid = 1'b1;
          grp_bits     = {4'b0000, val[1:0]};
        end
        default: begin
          r.data_byte  = {grp_bits[1:0], val};
          r.byte_valid = 1'b1;
          grp_bits     = 6'd0;
        end
      endcase
      grp_count = grp_count + 2'd1;
    end else if (cls == CLS_INVALID) begin
      // group state is untouched, only the flag depends on skip mode
      r.bad_char = ~cfg_skip;
    end
    if (it.eoi) begin
      // leftover count is reported, then the next character opens a new stream
      r.leftover_sextets = grp_count;
      grp_count = 2'd0;
      grp_bits  = 6'd0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result transaction", 1, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.data_byte !== want.data_byte)
      report_mismatch("data_byte", got.data_byte, want.data_byte);
    if (got.byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
    if (got.char_class !== want.char_class)
      report_mismatch("char_class", got.char_class, want.char_class);
    if (got.bad_char !== want.bad_char)
      report_mismatch("bad_char", got.bad_char, want.bad_char);
    if (got.leftover_sextets !== want.leftover_sextets)
      report_mismatch("leftover_sextets", got.leftover_sextets, want.leftover_sextets);
    if (got.last_out !== want.last_out)
      report_mismatch("last_out", got.last_out, want.last_out);
    bytes_seen   += want.byte_valid;
    bad_seen     += want.bad_char;
    streams_seen += want.last_out;
  endtask

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued characters, predicts each accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && full) full_stalls++;
      if (push && !full) begin
        pending_results.push_back(decode_step('{ch: in_char, eoi: end_of_input}));
        char_q.pop_front();
        items_sent++;
        tx_gap = tx_idle_on ? pick_gap() : 0;
      end
      // an offered transaction stays on the ports until the decoder takes it
      if (!(push && full)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (char_q.size() != 0) begin
          push         <= 1'b1;
          in_char      <= char_q[0].ch;
          end_of_input <= char_q[0].eoi;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: pops results with random stalls and checks them
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        compare_result('{data_byte: data_byte, byte_valid: byte_valid,
                         char_class: char_class, bad_char: bad_char,
                         leftover_sextets: leftover_sextets, last_out: last_out});
        results_seen++;
        rx_gap = rx_idle_on ? pick_gap() : 0;
        // long hold-off while the sender keeps going, so the queues fill and full rises
        if (results_seen == 200 || results_seen == 700) rx_hold_left = 150;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic add_char(input logic [7:0] ch, input logic eoi);
    char_q.push_back('{ch: ch, eoi: eoi});
  endtask

  // sender pause: nothing new until every transaction is accepted and answered
  task automatic wait_drained();
    while (char_q.size() != 0 || pending_results.size() != 0) @(posedge clk);
  endtask

  // only called while the decoder holds no work
  task automatic write_reg(input logic idx, input logic [1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ALPHABET_MODE) cfg_mode = val;
    else cfg_skip = val[0];
  endtask

  function automatic logic [7:0] glyph(input logic [5:0] v, input logic url);
    if (v < 6'd26) return 8'("A") + 8'(v);
    if (v < 6'd52) return 8'("a") + 8'(v - 6'd26);
    if (v < 6'd62) return 8'("0") + 8'(v - 6'd52);
    if (v == 6'd62) return url ? 8'("-") : 8'("+");
    return url ? 8'("_") : 8'("/");
  endfunction

  function automatic logic [7:0] any_space();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // a character the current alphabet accepts; for the dual modes either alphabet
  function automatic logic [7:0] good_char(input logic [1:0] mode);
    logic url;
    if (mode == MODE_STD) url = 1'b0;
    else if (mode == MODE_URL) url = 1'b1;
    else url = 1'($urandom_range(0, 1));
    // lean on the two mode-dependent symbols
    if ($urandom_range(0, 5) == 0) return glyph(6'($urandom_range(62, 63)), url);
    return glyph(6'($urandom_range(0, 63)), url);
  endfunction

  function automatic logic [7:0] junk_char(input logic [1:0] mode);
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h80, 8'hff));
      1: return 8'("=");
      2: return glyph(6'($urandom_range(62, 63)), mode != MODE_URL);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed streams, some broken ones, some raw noise
  task automatic fill_random(input int n_items);
    int added;
    int kind;
    int len;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // clean stream: whole groups most of the time, ragged tail otherwise
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 23) : 4 * $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) add_char(any_space(), 1'b0);
          add_char(good_char(cfg_mode), i == len - 1);
          added++;
        end
      end else if (kind < 90) begin
        // broken stream: stray junk characters, most of them invalid, end mark sometimes missing
        len = $urandom_range(2, 20);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0) add_char(junk_char(cfg_mode), 1'b0);
          else add_char(good_char(cfg_mode), (i == len - 1) && ($urandom_range(0, 1) == 1));
          added++;
        end
      end else begin
        // raw noise bytes
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          added++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic skip,
                           input logic tx_idle, input logic rx_idle, input int n_items);
    wait_drained();
    write_reg(REG_ALPHABET_MODE, mode);
    write_reg(REG_SKIP_INVALID, {1'b0, skip});
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    fill_random(n_items);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_ALPHABET_MODE, MODE_STD);
    write_reg(REG_SKIP_INVALID, 2'd0);

    // directed: alphabet edges, symbols of both alphabets under the standard one,
    // all whitespace, non-ascii and control bytes, each leftover count at end of stream
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    add_char("A", 1'b0);
    add_char("/", 1'b0);
    add_char("+", 1'b0);
    add_char("z", 1'b0);
    add_char("-", 1'b0);
    add_char("_", 1'b0);
    add_char(CH_SPACE, 1'b0);
    add_char(CH_TAB, 1'b0);
    add_char(CH_LF, 1'b0);
    add_char(CH_FF, 1'b0);
    add_char(CH_CR, 1'b0);
    add_char(8'h80, 1'b0);
    add_char(8'hff, 1'b0);
    add_char(8'h00, 1'b0);
    add_char("9", 1'b0);
    add_char("0", 1'b0);
    add_char("a", 1'b1);
    add_char("Z", 1'b1);
    add_char("Q", 1'b0);
    add_char("x", 1'b1);
    add_char("b", 1'b0);
    add_char("c", 1'b0);
    add_char("d", 1'b0);
    add_char("e", 1'b1);
    add_char(CH_SPACE, 1'b1);

    // random phases through every alphabet mode, including the spare code, and both
    // skip settings; idling on each side is switched per phase for clean bursts too
    run_phase(MODE_STD,   1'b0, 1'b1, 1'b1, 104);
    run_phase(MODE_URL,   1'b0, 1'b1, 1'b0, 104);
    run_phase(MODE_BOTH,  1'b1, 1'b0, 1'b1, 104);
    run_phase(MODE_SPARE, 1'b0, 1'b1, 1'b1, 104);
    run_phase(MODE_STD,   1'b1, 1'b0, 1'b0, 104);
    run_phase(MODE_URL,   1'b1, 1'b1, 1'b1, 104);
    run_phase(MODE_BOTH,  1'b0, 1'b1, 1'b0, 104);
    run_phase(MODE_SPARE, 1'b1, 1'b0, 1'b1, 104);

    wait_drained();
    // keep the clock running to catch any stray result behind the last one
    repeat (8) @(posedge clk);

    $display("covered %0d characters, %0d decoded bytes, %0d flagged characters, %0d streams",
             items_sent, bytes_seen, bad_seen, streams_seen);
    $display("all alphabet modes and skip settings, %0d cycles with the input held off by full",
             full_stalls);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d characters queued and %0d results outstanding",
             char_q.size(), pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
